@@ rtl/i64alu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i64alu_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int FIELD_W        = 64;
  localparam int OP_W           = 4;
  localparam int SHAMT_W        = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_NOT = 4'd8,
    OP_SHL = 4'd9,
    OP_SHR = 4'd10,
    OP_POW = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POW_CHK,
    ST_POW_ACC,
    ST_POW_SQR,
    ST_OUT
  } state_t;

  typedef enum logic {
    UNIT_MUL,
    UNIT_DIV
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/int64_alu_with_power_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// add, sub, logic, shifts and the zero-divisor case go from accept straight to the out state
// mul, div and mod run on the shared unit, one shift-add or restoring step a cycle
// pow does square-and-multiply, each multiply on the same unit
// throughput: one item at a time, in_stall stays high until the result sits in the out register
// reset: synchronous active-low rst_n returns the sequencer to idle and empties the out register

module int64_alu_with_power_unit
  import i64alu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [OP_W-1:0]           in_op,
  input  wire logic signed [FIELD_W-1:0] in_operand_a,
  input  wire logic signed [FIELD_W-1:0] in_operand_b,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [FIELD_W-1:0]      out_result,
  output logic                           out_error
);

  localparam int W = DATA_WIDTH;

  state_t       state_r, state_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         err_r, err_nxt;
  logic [W-1:0] base_r, base_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic [W-1:0] pacc_r, pacc_nxt;
  logic         negq_r, negq_nxt;
  logic         negr_r, negr_nxt;
  logic         isdiv_r, isdiv_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [FIELD_W-1:0] out_result_r, out_result_nxt;
  logic                      out_error_r, out_error_nxt;

  unit_ctrl_t   uctrl;
  logic [W-1:0] uopx, uopy;
  logic         udone;
  logic [W-1:0] uacc, uquo;

  logic [W-1:0]         a_w, b_w, a_mag, b_mag;
  logic [SHAMT_W-1:0]   amt;
  logic                 in_beat, out_free;

  assign a_w      = in_operand_a[W-1:0];
  assign b_w      = in_operand_b[W-1:0];
  assign a_mag    = a_w[W-1] ? (W'(0) - a_w) : a_w;
  assign b_mag    = b_w[W-1] ? (W'(0) - b_w) : b_w;
  assign amt      = in_operand_b[SHAMT_W-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  i64alu_unit #(
    .W (W)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (uctrl),
    .opx   (uopx),
    .opy   (uopy),
    .done  (udone),
    .acc   (uacc),
    .quo   (uquo)
  );

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    err_nxt        = err_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    pacc_nxt       = pacc_r;
    negq_nxt       = negq_r;
    negr_nxt       = negr_r;
    isdiv_nxt      = isdiv_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    uctrl.start    = 1'b0;
    uctrl.mode     = UNIT_MUL;
    uopx           = a_w;
    uopy           = b_w;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          err_nxt   = 1'b0;
          res_nxt   = '0;
          state_nxt = ST_OUT;
          unique case (op_t'(in_op))
            OP_ADD: res_nxt = a_w + b_w;
            OP_SUB: res_nxt = a_w - b_w;
            OP_MUL: begin
              uctrl.start = 1'b1;
              state_nxt   = ST_MUL;
            end
            OP_DIV, OP_MOD: begin
              if (b_w == '0) begin
                err_nxt = 1'b1;
              end else begin
                // most negative over minus one falls out of the magnitude path
                uctrl.start = 1'b1;
                uctrl.mode  = UNIT_DIV;
                uopx        = b_mag;
                uopy        = a_mag;
                negq_nxt    = a_w[W-1] ^ b_w[W-1];
                negr_nxt    = a_w[W-1];
                isdiv_nxt   = (op_t'(in_op) == OP_DIV);
                state_nxt   = ST_DIV;
              end
            end
            OP_AND: res_nxt = a_w & b_w;
            OP_OR:  res_nxt = a_w | b_w;
            OP_XOR: res_nxt = a_w ^ b_w;
            OP_NOT: res_nxt = ~a_w;
            OP_SHL: res_nxt = a_w << amt;
            OP_SHR: res_nxt = W'($signed(a_w) >>> amt);
            OP_POW: begin
              if (b_w[W-1] || b_w == '0) begin
                res_nxt = W'(1);
              end else begin
                base_nxt  = a_w;
                exp_nxt   = b_w;
                pacc_nxt  = W'(1);
                state_nxt = ST_POW_CHK;
              end
            end
            default: res_nxt = '0;
          endcase
        end
      end
      ST_MUL: begin
        if (udone) begin
          res_nxt   = uacc;
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (udone) begin
          if (isdiv_r) begin
            res_nxt = negq_r ? (W'(0) - uquo) : uquo;
          end else begin
            res_nxt = negr_r ? (W'(0) - uacc) : uacc;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_POW_CHK: begin
        if (exp_r == '0) begin
          res_nxt   = pacc_r;
          state_nxt = ST_OUT;
        end else if (exp_r[0]) begin
          uctrl.start = 1'b1;
          uopx        = pacc_r;
          uopy        = base_r;
          state_nxt   = ST_POW_ACC;
        end else begin
          uctrl.start = 1'b1;
          uopx        = base_r;
          uopy        = base_r;
          state_nxt   = ST_POW_SQR;
        end
      end
      ST_POW_ACC: begin
        if (udone) begin
          pacc_nxt  = uacc;
          exp_nxt   = {exp_r[W-1:1], 1'b0};
          state_nxt = ST_POW_CHK;
        end
      end
      ST_POW_SQR: begin
        if (udone) begin
          base_nxt  = uacc;
          exp_nxt   = {1'b0, exp_r[W-1:1]};
          state_nxt = ST_POW_CHK;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = FIELD_W'($signed(res_r));
          out_error_nxt  = err_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r        <= res_nxt;
    err_r        <= err_nxt;
    base_r       <= base_nxt;
    exp_r        <= exp_nxt;
    pacc_r       <= pacc_nxt;
    negq_r       <= negq_nxt;
    negr_r       <= negr_nxt;
    isdiv_r      <= isdiv_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

endmodule

`default_nettype wire

@@ rtl/i64alu_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i64alu_unit
  import i64alu_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire unit_ctrl_t   ctrl,
  input  wire logic [W-1:0] opx,
  input  wire logic [W-1:0] opy,
  output logic              done,
  output logic [W-1:0]      acc,
  output logic [W-1:0]      quo
);

  localparam int CNT_W = $clog2(W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  unit_mode_t       mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     x_r, x_nxt;
  logic [W-1:0]     y_r, y_nxt;

  // the one shared adder
  logic [W+1:0] add_a, add_b, sum;
  logic         add_cin;
  logic [W:0]   sh;

  assign sh  = {acc_r, y_r[W-1]};
  assign sum = add_a + add_b + {{(W+1){1'b0}}, add_cin};

  always_comb begin
    unique case (mode_r)
      UNIT_MUL: begin
        add_a   = {2'b00, acc_r};
        add_b   = y_r[0] ? {2'b00, x_r} : '0;
        add_cin = 1'b0;
      end
      UNIT_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        add_a   = {1'b0, sh};
        add_b   = ~{2'b00, x_r};
        add_cin = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      mode_nxt = ctrl.mode;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = opx;
      y_nxt    = opy;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (mode_r)
        UNIT_MUL: begin
          acc_nxt = sum[W-1:0];
          x_nxt   = {x_r[W-2:0], 1'b0};
          y_nxt   = {1'b0, y_r[W-1:1]};
        end
        UNIT_DIV: begin
          if (!sum[W+1]) begin
            acc_nxt = sum[W-1:0];
            y_nxt   = {y_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = sh[W-1:0];
            y_nxt   = {y_r[W-2:0], 1'b0};
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= UNIT_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign quo  = y_r;

endmodule

`default_nettype wire

@@ bench/alu_result_check.sv @@
`timescale 1ns / 1ps

module alu_result_check
  import i64alu_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [OP_W-1:0]           in_op,
  input  logic signed [FIELD_W-1:0] in_operand_a,
  input  logic signed [FIELD_W-1:0] in_operand_b,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [FIELD_W-1:0] out_result,
  input  logic                      out_error,
  output int                        fault_count,
  output int                        pending_beats
);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] result;
    logic               error;
  } alu_expect_t;

  alu_expect_t expected_results[$];

  initial begin
    fault_count   = 0;
    pending_beats = 0;
  end

  // cut to W bits, sign-extend back to the field width
  function automatic logic [63:0] wrap_w(input logic [63:0] x);
    logic [63:0] keep;
    keep = (W == 64) ? '1 : ((64'd1 << W) - 64'd1);
    x = x & keep;
    if (x[W-1]) x = x | ~keep;
    return x;
  endfunction

  function automatic logic [63:0] pow_wrapped(input logic [63:0] base, input logic [63:0] ex);
    logic [63:0] acc;
    acc = 64'd1;
    if (ex[63] || ex == 64'd0) return acc;
    while (ex != 64'd0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex   = ex >> 1;
    end
    return acc;
  endfunction

  function automatic alu_expect_t alu_compute(input logic [OP_W-1:0] op,
                                              input logic [63:0] a_raw,
                                              input logic [63:0] b_raw);
    logic [63:0] a, b, r, ua, ub;
    logic        err;
    int unsigned amount;
    alu_expect_t res;
    a      = wrap_w(a_raw);
    b      = wrap_w(b_raw);
    r      = '0;
    err    = 1'b0;
    amount = b[5:0];
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          err = 1'b1;
        end else if (a == wrap_w(64'd1 << (W - 1)) && b == '1) begin
          r = (op == OP_DIV) ? a : '0;
        end else begin
          ua = a[63] ? 64'd0 - a : a;
          ub = b[63] ? 64'd0 - b : b;
          if (op == OP_DIV) r = (a[63] != b[63]) ? 64'd0 - (ua / ub) : ua / ub;
          else r = a[63] ? 64'd0 - (ua % ub) : ua % ub;
        end
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_NOT: r = ~a;
      OP_SHL: r = a << amount;
      OP_SHR: r = $signed(a) >>> amount;
      OP_POW: r = pow_wrapped(a, b);
      default: r = '0;
    endcase
    res.op     = op;
    res.a      = a_raw;
    res.b      = b_raw;
    res.result = err ? '0 : wrap_w(r);
    res.error  = err;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_expect_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected out beat: result %h error %0b", out_result, out_error);
        end else begin
          want = expected_results.pop_front();
          if (out_result !== want.result || out_error !== want.error) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch op %0d a %h b %h: result %h exp %h, error %0b exp %0b",
                       want.op, want.a, want.b, out_result, want.result,
                       out_error, want.error);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(alu_compute(in_op, in_operand_a, in_operand_b));
      pending_beats <= expected_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import i64alu_pkg::*;

  localparam logic [OP_W-1:0]    OP_SPARE_LO = 4'd12;
  localparam logic [OP_W-1:0]    OP_SPARE_HI = 4'd15;
  localparam logic [FIELD_W-1:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [FIELD_W-1:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [FIELD_W-1:0] ALL1  = '1;
  localparam int N_RANDOM  = 1800;
  localparam int CALM_FROM = 1500;
  localparam int BIG_POW_CAP = 30;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_op = '0;
  logic signed [FIELD_W-1:0] in_operand_a = '0;
  logic signed [FIELD_W-1:0] in_operand_b = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FIELD_W-1:0] out_result;
  logic                      out_error;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   run_left = 0;
  int   fault_count;
  int   pending_beats;
  int   big_pows = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int64_alu_with_power_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result),
    .out_error    (out_error)
  );

  alu_result_check checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_error     (out_error),
    .fault_count   (fault_count),
    .pending_beats (pending_beats)
  );

  // receiver: random stall bursts, one long hold-off, quiet at the end
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 5);
          else run_left = $urandom_range(1, 30);
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          run_left--;
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic [FIELD_W-1:0] pick_operand();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 64'd1;
      2: v = ALL1;
      3: v = MIN64;
      4: v = MAX64;
      5: v = {32'd0, 32'($urandom_range(0, 200))} - 64'd100;
      6: v = 64'd1 << $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] a,
                           input logic [FIELD_W-1:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] a, b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners of every operation
    send_item(OP_ADD, MAX64, 64'd1);
    send_item(OP_SUB, MIN64, 64'd1);
    send_item(OP_MUL, MIN64, ALL1);
    send_item(OP_MUL, MAX64, MAX64);
    send_item(OP_DIV, MAX64, '0);
    send_item(OP_MOD, -64'sd7, '0);
    send_item(OP_DIV, MIN64, ALL1);
    send_item(OP_MOD, MIN64, ALL1);
    send_item(OP_DIV, -64'sd7, 64'd2);
    send_item(OP_MOD, -64'sd7, 64'd2);
    send_item(OP_MOD, 64'd7, -64'sd2);
    send_item(OP_DIV, MIN64, 64'd3);
    send_item(OP_AND, ALL1, {$urandom, $urandom});
    send_item(OP_OR, '0, {$urandom, $urandom});
    send_item(OP_XOR, {$urandom, $urandom}, ALL1);
    send_item(OP_NOT, MIN64, {$urandom, $urandom});
    send_item(OP_SHL, ALL1, 64'd63);
    send_item(OP_SHL, 64'd1, 64'd65);
    send_item(OP_SHR, MIN64, 64'd63);
    send_item(OP_SHR, MAX64, 64'd69);
    send_item(OP_POW, 64'd3, 64'd40);
    send_item(OP_POW, 64'd2, 64'd63);
    send_item(OP_POW, {$urandom, $urandom}, '0);
    send_item(OP_POW, 64'd5, -64'sd5);
    send_item(OP_POW, ALL1, MAX64);
    send_item(OP_SPARE_LO, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(OP_SPARE_HI, {$urandom, $urandom}, {$urandom, $urandom});

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 60) hold_req <= 1'b1;
      if (n == CALM_FROM) calm <= 1'b1;
      if ($urandom_range(0, 99) < 4) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else op = OP_W'($urandom_range(OP_ADD, OP_POW));
      a = pick_operand();
      b = pick_operand();
      if (op == OP_POW) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: b = 64'($urandom_range(0, 255));
          6: b = {1'b1, 31'($urandom), $urandom};
          default: ;
        endcase
        // long exponents are slow, keep only a few of them
        if (!b[63] && b > 64'd255) begin
          if (big_pows < BIG_POW_CAP) big_pows++;
          else b = b & 64'd255;
        end
      end
      send_item(op, a, b);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fault_count == 0 && pending_beats == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/i64alu_pkg.sv
rtl/i64alu_unit.sv
rtl/int64_alu_with_power_unit.sv
bench/alu_result_check.sv
bench/tb_top.sv
